// File: rtl/core/assert_macros.svh
// assertion macros included by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clk outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rrsched_pkg.sv
// types and constants of the round-robin thread scheduler
package rrsched_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_SLEEP = 2'd2,
    CMD_BLOCK = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ZERO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_THREE = 3'd5;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  target_thread;
    logic [31:0] sleep_ticks;
    logic        block_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  running_thread;
    logic        switch_request;
    logic [3:0]  fired_events;
    logic [7:0]  woken_threads;
    logic        none_runnable;
    logic [31:0] time_now;
  } result_t;

endpackage

// File: rtl/core/rr_thread_scheduler_sleep_periodic.sv
// round-robin thread scheduler with sleep timers and periodic events
//
// usage
// - command channel: item is transferred at a rising clk with start high and
//   busy low; busy stays high until the result for that command is out
// - result channel: result is valid for exactly one cycle, marked by
//   result_valid; the receiver cannot stall, so nothing ever backs up
// - config channel: cfg_valid/cfg_ready write cfg_data to register cfg_index;
//   cfg_ready is low while busy and while a command is offered on start
// - steps from transfer to result strobe, one shared 32-bit add/compare
//   unit stepped by the sequencer:
//     tick      S_TICK_INC, S_TICK_EVT per active event, then S_TICK_THR
//               per ring thread; schedule S_SCHED, one candidate per cycle
//     sleep     S_SLEEP, block S_BLOCK
// - a new command is taken in the same cycle as the previous result strobe
// - reset (rst, synchronous): time 0, thread 0, all threads awake and
//   unblocked, periods 0, event i due at time i, one thread, no events
module rr_thread_scheduler_sleep_periodic #(
  parameter int THREAD_SLOTS = 8,
  parameter int EVENT_SLOTS  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rrsched_pkg::in_item_t             item,
  output logic                              result_valid,
  output rrsched_pkg::result_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrsched_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);
  import rrsched_pkg::*;

  `include "assert_macros.svh"

  // index widths and count widths (counts hold the slot number itself)
  localparam int TW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int EW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CW  = $clog2(THREAD_SLOTS + 1);
  localparam int ECW = $clog2(EVENT_SLOTS + 1);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TICK_INC = 7'b0000010,
    S_TICK_EVT = 7'b0000100,
    S_TICK_THR = 7'b0001000,
    S_SCHED    = 7'b0010000,
    S_SLEEP    = 7'b0100000,
    S_BLOCK    = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [3:0]  thread_count;
  logic [2:0]  event_count;
  logic [31:0] periods [EVENT_SLOTS];

  // scheduler state
  logic [31:0] sys_time;
  logic [TW-1:0] cur;
  logic [THREAD_SLOTS-1:0] asleep;
  logic [THREAD_SLOTS-1:0] blocked;
  logic [31:0] wake_times [THREAD_SLOTS];
  logic [31:0] due_times [EVENT_SLOTS];

  // sequencer working registers
  in_item_t item_q;
  logic [TW-1:0]  scan_idx;
  logic [CW-1:0]  scan_cnt;
  logic [EW-1:0]  ev_idx;
  logic [EVENT_SLOTS-1:0]  fired;
  logic [THREAD_SLOTS-1:0] woken;
  logic sw_r;
  logic none_r;

  // effective ring size and active event count
  logic [CW-1:0]  ring_n;
  logic [ECW-1:0] ev_n;

  always_comb begin
    if (thread_count == 4'd0) begin
      ring_n = CW'(1);
    end else if ({28'd0, thread_count} > 32'(THREAD_SLOTS)) begin
      ring_n = CW'(THREAD_SLOTS);
    end else begin
      ring_n = CW'(thread_count);
    end
    if ({29'd0, event_count} > 32'(EVENT_SLOTS)) begin
      ev_n = ECW'(EVENT_SLOTS);
    end else begin
      ev_n = ECW'(event_count);
    end
  end

  // shared arithmetic unit: three-input add plus compare of d against b
  logic [31:0] alu_a, alu_b, alu_c, alu_d;
  logic [31:0] alu_sum;
  logic        alu_eq, alu_le;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    alu_d = '0;
    case (state)
      S_TICK_INC: begin
        alu_a = sys_time;
        alu_c = 32'd1;
      end
      S_TICK_EVT: begin
        // rearm value is period + time + event index
        alu_a = periods[ev_idx];
        alu_b = sys_time;
        alu_c = 32'(ev_idx);
        alu_d = due_times[ev_idx];
      end
      S_TICK_THR: begin
        alu_b = sys_time;
        alu_d = wake_times[scan_idx];
      end
      S_SLEEP: begin
        alu_a = sys_time;
        alu_b = item_q.sleep_ticks;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + alu_c;
  assign alu_eq  = (alu_d == alu_b);
  assign alu_le  = (alu_d <= alu_b);

  // first schedule candidate: the thread after the current one, or thread 0
  logic [CW-1:0] cand_first;
  logic [CW-1:0] cand_inc;
  logic [TW-1:0] sched_start;
  logic [TW-1:0] sched_next;

  always_comb begin
    cand_first  = CW'(cur) + CW'(1);
    sched_start = (cand_first >= ring_n) ? '0 : TW'(cand_first);
    cand_inc    = CW'(scan_idx) + CW'(1);
    sched_next  = (cand_inc >= ring_n) ? '0 : TW'(cand_inc);
  end

  logic accept;
  logic [1:0] period_k;
  assign accept   = start && (state == S_IDLE);
  assign period_k = 2'(cfg_index - CFG_PERIOD_ZERO);

  // command latch, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      thread_count <= 4'd1;
      event_count  <= 3'd0;
      sys_time     <= '0;
      cur          <= '0;
      asleep       <= '0;
      blocked      <= '0;
      scan_idx     <= '0;
      scan_cnt     <= '0;
      ev_idx       <= '0;
      fired        <= '0;
      woken        <= '0;
      sw_r         <= 1'b0;
      none_r       <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        wake_times[i] <= '0;
      end
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        periods[i]   <= '0;
        due_times[i] <= 32'(i);
      end
    end else begin
      result_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (start) begin
            fired    <= '0;
            woken    <= '0;
            sw_r     <= 1'b0;
            none_r   <= 1'b0;
            scan_idx <= '0;
            scan_cnt <= '0;
            ev_idx   <= '0;
            case (item.cmd)
              CMD_TICK: begin
                sw_r  <= 1'b1;
                state <= S_TICK_INC;
              end
              CMD_SCHED: begin
                scan_idx <= sched_start;
                state    <= S_SCHED;
              end
              CMD_SLEEP: begin
                sw_r  <= 1'b1;
                state <= S_SLEEP;
              end
              default: begin
                state <= S_BLOCK;
              end
            endcase
          end
        end

        S_TICK_INC: begin
          sys_time <= alu_sum;
          if (ev_n != '0) begin
            state <= S_TICK_EVT;
          end else begin
            state <= S_TICK_THR;
          end
        end

        S_TICK_EVT: begin
          // due <= time: fire and rearm
          if (alu_le) begin
            due_times[ev_idx] <= alu_sum;
            fired[ev_idx]     <= 1'b1;
          end
          if (ECW'(ev_idx) == ev_n - ECW'(1)) begin
            state <= S_TICK_THR;
          end else begin
            ev_idx <= EW'(ev_idx + 1'b1);
          end
        end

        S_TICK_THR: begin
          // sleeper whose wake time matches the time wakes up
          if (asleep[scan_idx] && alu_eq) begin
            asleep[scan_idx]     <= 1'b0;
            wake_times[scan_idx] <= '0;
            woken[scan_idx]      <= 1'b1;
          end
          if (CW'(scan_idx) == ring_n - CW'(1)) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            scan_idx <= TW'(scan_idx + 1'b1);
          end
        end

        S_SCHED: begin
          if (!asleep[scan_idx] && !blocked[scan_idx]) begin
            cur          <= scan_idx;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (scan_cnt == ring_n - CW'(1)) begin
            // whole ring visited, keep the current thread
            none_r       <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
            scan_idx <= sched_next;
          end
        end

        S_SLEEP: begin
          wake_times[cur] <= alu_sum;
          asleep[cur]     <= 1'b1;
          result_valid    <= 1'b1;
          state           <= S_IDLE;
        end

        S_BLOCK: begin
          if ({29'd0, item_q.target_thread} < 32'(THREAD_SLOTS)) begin
            blocked[TW'(item_q.target_thread)] <= item_q.block_value;
          end
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // config transfer, only while idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THREAD_COUNT: begin
            thread_count <= cfg_data[3:0];
          end
          CFG_EVENT_COUNT: begin
            event_count <= cfg_data[2:0];
          end
          CFG_PERIOD_ZERO, CFG_PERIOD_ONE, CFG_PERIOD_TWO, CFG_PERIOD_THREE: begin
            // writing a period rearms its event at period + index
            if (32'(period_k) < 32'(EVENT_SLOTS)) begin
              periods[EW'(period_k)]   <= cfg_data;
              due_times[EW'(period_k)] <= cfg_data + 32'(period_k);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // masks and thread index padded to the result field widths
  logic [EVENT_SLOTS+3:0]  fired_pad;
  logic [THREAD_SLOTS+7:0] woken_pad;
  logic [TW+2:0]           cur_pad;

  assign fired_pad = {4'd0, fired};
  assign woken_pad = {8'd0, woken};
  assign cur_pad   = {3'd0, cur};

  always_comb begin
    result.running_thread = cur_pad[2:0];
    result.switch_request = sw_r;
    result.fired_events   = fired_pad[3:0];
    result.woken_threads  = woken_pad[7:0];
    result.none_runnable  = none_r;
    result.time_now       = sys_time;
  end

  // checks
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command transfer did not raise busy")
  `ASSERT_SAME(a_strobe_idle, result_valid, !busy, "result strobe while sequencer busy")
  `ASSERT_SAME(a_none_no_switch, result_valid, !(none_r && sw_r),
               "none_runnable and switch_request together")
  `ASSERT_SAME(a_scan_in_ring, state == S_TICK_THR || state == S_SCHED,
               CW'(scan_idx) < ring_n, "thread scan index outside the ring")

endmodule

// File: bench/tb_top.sv
// self-checking bench for the round-robin thread scheduler with sleep timers
`timescale 1ns / 100ps

module tb_top;
  import rrsched_pkg::*;

  localparam int THREAD_SLOTS = 8;
  localparam int EVENT_SLOTS  = 4;
  // slowest legal run stays far below this limit, leave plenty of margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 20;

  // every input of the block has a known value from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             item = '0;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THREAD_COUNT;
  logic [31:0]          cfg_data = '0;

  rr_thread_scheduler_sleep_periodic #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .EVENT_SLOTS (EVENT_SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // scheduler state as the bench sees it, advanced once per command transfer
  // ---------------------------------------------------------------------
  logic [31:0] sched_time;
  logic [2:0]  sched_thread;
  logic        thread_asleep  [THREAD_SLOTS];
  logic        thread_blocked [THREAD_SLOTS];
  logic [31:0] thread_wake    [THREAD_SLOTS];
  logic [31:0] event_due      [EVENT_SLOTS];
  logic [31:0] event_period   [EVENT_SLOTS];
  logic [3:0]  ring_setting;
  logic [2:0]  event_setting;

  // commands waiting to go out, and the results they must produce, oldest first
  in_item_t cmd_backlog[$];
  result_t  pending_results[$];

  int gap_pct;        // chance in percent that the sender idles on a free cycle
  int sent_count;     // commands put on the port so far
  int cmd_count;
  int result_count;
  int error_count;
  int fired_total;
  int woken_total;
  int stalled_scheds;
  int cycle_count;

  // state after reset: one thread, no events, event i due at time i
  function automatic void reset_model();
    sched_time    = '0;
    sched_thread  = '0;
    ring_setting  = 4'd1;
    event_setting = 3'd0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      thread_asleep[i]  = 1'b0;
      thread_blocked[i] = 1'b0;
      thread_wake[i]    = '0;
    end
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      event_period[i] = '0;
      event_due[i]    = 32'(i);
    end
  endfunction

  // a period write also rearms its event
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    logic [1:0] k;
    k = 2'(idx - CFG_PERIOD_ZERO);
    case (idx)
      CFG_THREAD_COUNT: ring_setting  = data[3:0];
      CFG_EVENT_COUNT:  event_setting = data[2:0];
      CFG_PERIOD_ZERO, CFG_PERIOD_ONE, CFG_PERIOD_TWO, CFG_PERIOD_THREE: begin
        event_period[k] = data;
        event_due[k]    = data + 32'(k);
      end
      default: begin
      end
    endcase
  endfunction

  // advance the scheduler state by one command and return what it reports
  function automatic result_t next_sched_result(in_item_t cmd_in);
    result_t     r;
    int          ring;
    int          active;
    int          cand;
    bit          found;
    r      = '0;
    found  = 1'b0;
    // a zero ring counts as one thread, oversized settings saturate
    ring   = (ring_setting == 0) ? 1 :
             (ring_setting > THREAD_SLOTS) ? THREAD_SLOTS : int'(ring_setting);
    active = (event_setting > EVENT_SLOTS) ? EVENT_SLOTS : int'(event_setting);
    case (cmd_in.cmd)
      CMD_TICK: begin
        sched_time = sched_time + 32'd1;
        // due events fire in index order and rearm at period + time + index
        for (int i = 0; i < active; i++) begin
          if (event_due[i] <= sched_time) begin
            event_due[i] = event_period[i] + sched_time + 32'(i);
            r.fired_events[i] = 1'b1;
          end
        end
        // only threads inside the ring are woken
        for (int i = 0; i < ring; i++) begin
          if (thread_asleep[i] && thread_wake[i] == sched_time) begin
            thread_asleep[i] = 1'b0;
            thread_wake[i]   = '0;
            r.woken_threads[i] = 1'b1;
          end
        end
        r.switch_request = 1'b1;
      end
      CMD_SCHED: begin
        // search starts after the current thread; a thread past the ring wraps to 0
        cand = int'(sched_thread) + 1;
        for (int i = 0; i < ring; i++) begin
          if (!found) begin
            if (cand >= ring) cand = 0;
            if (!thread_asleep[cand] && !thread_blocked[cand]) begin
              sched_thread = 3'(cand);
              found = 1'b1;
            end else begin
              cand++;
            end
          end
        end
        r.none_runnable = !found;
      end
      CMD_SLEEP: begin
        // the current thread sleeps even when it sits outside the ring
        thread_wake[sched_thread]   = sched_time + cmd_in.sleep_ticks;
        thread_asleep[sched_thread] = 1'b1;
        r.switch_request = 1'b1;
      end
      default: begin
        thread_blocked[cmd_in.target_thread] = cmd_in.block_value;
      end
    endcase
    r.running_thread = sched_thread;
    r.time_now       = sched_time;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // driver: new commands go out on the falling edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
      end
      if (start && !busy) begin
        pending_results.push_back(next_sched_result(item));
        cmd_count++;
      end
    end
  end

  always @(negedge clk) begin
    // a command that is still waiting for its transfer is held as it is
    if (sent_count == cmd_count) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        item  <= cmd_backlog.pop_front();
        start <= 1'b1;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: results are taken on the rising edge that ends their strobe
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with no command outstanding, actual %0h", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("running_thread", 32'(want.running_thread), 32'(result.running_thread));
        check_field("switch_request", 32'(want.switch_request), 32'(result.switch_request));
        check_field("fired_events",   32'(want.fired_events),   32'(result.fired_events));
        check_field("woken_threads",  32'(want.woken_threads),  32'(result.woken_threads));
        check_field("none_runnable",  32'(want.none_runnable),  32'(result.none_runnable));
        check_field("time_now",       want.time_now,            result.time_now);
        result_count++;
        fired_total    += $countones(result.fired_events);
        woken_total    += $countones(result.woken_threads);
        stalled_scheds += result.none_runnable;
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_cmd(cmd_t op, logic [2:0] target, logic [31:0] ticks, logic bval);
    in_item_t c;
    c.cmd           = op;
    c.target_thread = target;
    c.sleep_ticks   = ticks;
    c.block_value   = bval;
    cmd_backlog.push_back(c);
  endtask

  // mix weighted toward ticks and schedules so sleepers wake and the ring turns
  task automatic queue_random(int count);
    in_item_t c;
    int       roll;
    for (int n = 0; n < count; n++) begin
      roll            = $urandom_range(99);
      c.target_thread = 3'($urandom_range(7));
      c.block_value   = ($urandom_range(99) < 40);
      c.sleep_ticks   = $urandom;
      if (roll < 40) c.cmd = CMD_TICK;
      else if (roll < 70) c.cmd = CMD_SCHED;
      else if (roll < 85) c.cmd = CMD_SLEEP;
      else c.cmd = CMD_BLOCK;
      // sleeps are mostly short so threads come back within the run
      if (c.cmd == CMD_SLEEP) begin
        roll = $urandom_range(99);
        if (roll < 75) c.sleep_ticks = $urandom_range(12);
        else if (roll < 95) c.sleep_ticks = $urandom_range(200, 13);
      end
      cmd_backlog.push_back(c);
    end
  endtask

  // hold off until every command is out and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0 || busy);
  endtask

  // the bench model picks up the write at the transfer edge
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  // every register is rewritten at each phase boundary, block idle
  task automatic program_sched(logic [31:0] threads, logic [31:0] events,
                               logic [31:0] p0, logic [31:0] p1,
                               logic [31:0] p2, logic [31:0] p3);
    cfg_write(CFG_THREAD_COUNT, threads);
    cfg_write(CFG_EVENT_COUNT,  events);
    cfg_write(CFG_PERIOD_ZERO,  p0);
    cfg_write(CFG_PERIOD_ONE,   p1);
    cfg_write(CFG_PERIOD_TWO,   p2);
    cfg_write(CFG_PERIOD_THREE, p3);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    gap_pct = 28;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // single thread ring under reset settings
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);          // lone thread stays current
    push_cmd(CMD_BLOCK, 3'd0, 32'd0, 1'b1);
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);          // nothing runnable, thread kept
    push_cmd(CMD_BLOCK, 3'd0, 32'd0, 1'b0);
    push_cmd(CMD_BLOCK, 3'd7, 32'hFFFF_FFFF, 1'b1);  // highest slot, outside the ring
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);
    push_cmd(CMD_SLEEP, 3'd0, 32'd0, 1'b0);          // zero sleep, wakes only after wrap
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);          // current thread asleep
    push_cmd(CMD_SLEEP, 3'd0, 32'hFFFF_FFFF, 1'b0);  // longest sleep
    push_cmd(CMD_SLEEP, 3'd0, 32'd1, 1'b0);          // rewrites wake time
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);          // thread 0 wakes
    wait_drained();

    // full ring, all events, periods at both extremes
    program_sched(32'd8, 32'd4, 32'd0, 32'd1, 32'd3, 32'hFFFF_FFFF);
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);
    push_cmd(CMD_BLOCK, 3'd2, 32'd0, 1'b1);
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);          // skips the blocked thread
    push_cmd(CMD_SLEEP, 3'd0, 32'd2, 1'b0);
    push_cmd(CMD_SCHED, 3'd0, 32'd0, 1'b0);
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);
    push_cmd(CMD_TICK,  3'd0, 32'd0, 1'b0);          // sleeper comes back
    push_cmd(CMD_BLOCK, 3'd7, 32'd0, 1'b0);
    push_cmd(CMD_BLOCK, 3'd2, 32'd0, 1'b0);
    queue_random(350);
    wait_drained();

    // short ring so the current thread can sit beyond it; sender mostly idle
    gap_pct = 80;
    program_sched(32'd3, 32'd2, 32'($urandom_range(12)), 32'($urandom_range(12)),
                  $urandom, 32'($urandom_range(12)));
    queue_random(350);
    wait_drained();

    // zero ring and oversized event count, back to back
    gap_pct = 0;
    program_sched(32'd0, 32'd7, 32'($urandom_range(6)), 32'($urandom_range(6)),
                  32'($urandom_range(6)), 32'($urandom_range(6)));
    queue_random(150);
    wait_drained();

    // oversized ring, event count just past the slots
    program_sched(32'd15, 32'd5, 32'($urandom_range(9)), $urandom,
                  32'($urandom_range(9)), 32'd0);
    queue_random(350);
    wait_drained();

    // allow a stray late strobe to show up
    repeat (30) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results outstanding, expected 0 actual %0d",
               $time, pending_results.size());
    end

    $display("covered %0d commands, %0d results checked, final time %0d",
             cmd_count, result_count, sched_time);
    $display("events fired %0d, threads woken %0d, schedules with no runnable thread %0d",
             fired_total, woken_total, stalled_scheds);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
